>>> sv/r0split_pkg.sv
// ----------------------------------------------------------------------------
// r0split_pkg
// shared widths, codes and the job record passed from front to back
// ----------------------------------------------------------------------------
package r0split_pkg;

    // field widths
    localparam int ADDR_W   = 31;
    localparam int CNT_W    = 7;
    localparam int UNIT_W   = 9;
    localparam int NDISK_W  = 5;
    localparam int DISK_W   = 4;
    localparam int DIV_W    = UNIT_W + NDISK_W;
    localparam int STEP_W   = $clog2(ADDR_W);
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W    = UNIT_W;

    // parameter defaults
    localparam int DEF_MAX_DISKS   = 16;
    localparam int DEF_MAX_UNIT    = 256;
    localparam int DEF_MAX_REQUEST = 64;

    // reset values of the config registers
    localparam logic [UNIT_W-1:0]  RST_STRIPE_UNIT = UNIT_W'(4);
    localparam logic [NDISK_W-1:0] RST_DISK_COUNT  = NDISK_W'(2);

    // job queue depth
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STRIPE_UNIT = 1'b0,
        CFG_DISK_COUNT  = 1'b1
    } t_cfg_index;

    typedef enum logic [1:0] {
        ST_CHUNK  = 2'd0,
        ST_FAILED = 2'd1,
        ST_ACK    = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        FS_IDLE,
        FS_DIV,
        FS_MOD,
        FS_MUL,
        FS_PUSH
    } t_front_state;

    typedef struct packed {
        logic                single;
        t_status             status;
        logic [NDISK_W-1:0]  disk;
        logic [ADDR_W-1:0]   row_base;
        logic [UNIT_W-1:0]   offset;
        logic [ADDR_W-1:0]   lba;
        logic [CNT_W-1:0]    left;
        logic [UNIT_W-1:0]   unit;
        logic [NDISK_W-1:0]  ndisks;
        logic                wr;
    } t_job;

endpackage

>>> sv/r0split_front.sv
// ----------------------------------------------------------------------------
// r0split_front
// accepts requests, tracks volume failure and maps the start address
// ----------------------------------------------------------------------------
module r0split_front
    import r0split_pkg::*;
#(
    parameter int MAX_DISKS   = DEF_MAX_DISKS,
    parameter int MAX_UNIT    = DEF_MAX_UNIT,
    parameter int MAX_REQUEST = DEF_MAX_REQUEST
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [UNIT_W-1:0]   i_stripe_unit,
    input  logic [NDISK_W-1:0]  i_disk_count,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic                i_action,
    input  logic                i_is_write,
    input  logic [ADDR_W-1:0]   i_first_block,
    input  logic [CNT_W-1:0]    i_block_count,
    input  logic [DISK_W-1:0]   i_failing_disk,
    output logic                o_push_valid,
    input  logic                i_push_ready,
    output t_job                o_push_job
);

    localparam int PROD_W = ADDR_W + UNIT_W;

    t_front_state r_state, n_state;

    logic               r_failed, n_failed;
    logic [DISK_W-1:0]  r_dead, n_dead;
    logic               r_single, n_single;
    t_status            r_status, n_status;
    logic [NDISK_W-1:0] r_disk, n_disk;
    logic [ADDR_W-1:0]  r_quot, n_quot;
    logic [DIV_W-1:0]   r_rem, n_rem;
    logic [DIV_W-1:0]   r_div, n_div;
    logic [STEP_W-1:0]  r_cnt, n_cnt;
    logic [ADDR_W-1:0]  r_lba, n_lba;
    logic [CNT_W-1:0]   r_left, n_left;
    logic [UNIT_W-1:0]  r_unit, n_unit;
    logic [NDISK_W-1:0] r_n, n_n;
    logic               r_wr, n_wr;
    logic [ADDR_W-1:0]  r_row_base, n_row_base;

    logic               in_fire;
    logic               single_case;
    logic [UNIT_W-1:0]  unit_eff;
    logic [NDISK_W-1:0] n_eff;
    logic [CNT_W-1:0]   left_eff;
    logic [DIV_W:0]     rem_sh;
    logic               div_ge;
    logic [DIV_W-1:0]   mod_sub;
    logic               mod_ge;
    logic [PROD_W-1:0]  prod;

    assign in_fire     = i_in_valid && o_in_ready;
    assign single_case = i_action || r_failed || (i_block_count == '0);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            FS_IDLE: begin
                if (i_in_valid) begin
                    n_state = single_case ? FS_PUSH : FS_DIV;
                end
            end
            FS_DIV: begin
                if (r_cnt == '0) begin
                    n_state = FS_MOD;
                end
            end
            FS_MOD: begin
                if (r_cnt == '0) begin
                    n_state = FS_MUL;
                end
            end
            FS_MUL:  n_state = FS_PUSH;
            FS_PUSH: begin
                if (i_push_ready) begin
                    n_state = FS_IDLE;
                end
            end
            default: n_state = FS_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_in_ready   = 1'b0;
        o_push_valid = 1'b0;
        case (r_state)
            FS_IDLE: o_in_ready   = 1'b1;
            FS_PUSH: o_push_valid = 1'b1;
            default: begin
                o_in_ready   = 1'b0;
                o_push_valid = 1'b0;
            end
        endcase
    end

    // clamped configuration and request size
    always_comb begin
        if (i_stripe_unit == '0) begin
            unit_eff = UNIT_W'(1);
        end else if (32'(i_stripe_unit) > 32'(MAX_UNIT)) begin
            unit_eff = UNIT_W'(MAX_UNIT);
        end else begin
            unit_eff = i_stripe_unit;
        end
        if (i_disk_count == '0) begin
            n_eff = NDISK_W'(1);
        end else if (32'(i_disk_count) > 32'(MAX_DISKS)) begin
            n_eff = NDISK_W'(MAX_DISKS);
        end else begin
            n_eff = i_disk_count;
        end
        if (32'(i_block_count) > 32'(MAX_REQUEST)) begin
            left_eff = CNT_W'(MAX_REQUEST);
        end else begin
            left_eff = i_block_count;
        end
    end

    // address / (unit * disks) one bit a cycle, then remainder / unit
    assign rem_sh  = {r_rem, r_quot[ADDR_W-1]};
    assign div_ge  = rem_sh >= {1'b0, r_div};
    assign mod_sub = DIV_W'(r_unit) << r_cnt;
    assign mod_ge  = r_rem >= mod_sub;
    assign prod    = PROD_W'(r_quot) * PROD_W'(r_unit);

    always_comb begin
        n_failed   = r_failed;
        n_dead     = r_dead;
        n_single   = r_single;
        n_status   = r_status;
        n_disk     = r_disk;
        n_quot     = r_quot;
        n_rem      = r_rem;
        n_div      = r_div;
        n_cnt      = r_cnt;
        n_lba      = r_lba;
        n_left     = r_left;
        n_unit     = r_unit;
        n_n        = r_n;
        n_wr       = r_wr;
        n_row_base = r_row_base;
        case (r_state)
            FS_IDLE: begin
                if (in_fire) begin
                    n_wr     = i_is_write;
                    n_single = single_case;
                    n_lba    = i_first_block;
                    n_quot   = i_first_block;
                    n_rem    = '0;
                    n_div    = DIV_W'(unit_eff) * DIV_W'(n_eff);
                    n_cnt    = STEP_W'(ADDR_W - 1);
                    n_left   = left_eff;
                    n_unit   = unit_eff;
                    n_n      = n_eff;
                    n_disk   = '0;
                    n_status = ST_CHUNK;
                    if (i_action) begin
                        n_failed = 1'b1;
                        n_dead   = i_failing_disk;
                        n_status = ST_ACK;
                        n_disk   = NDISK_W'(i_failing_disk);
                    end else if (r_failed) begin
                        n_status = ST_FAILED;
                        n_disk   = NDISK_W'(r_dead);
                    end else if (i_block_count == '0) begin
                        n_status = ST_ACK;
                    end
                end
            end
            FS_DIV: begin
                n_rem  = div_ge ? DIV_W'(rem_sh - {1'b0, r_div}) : DIV_W'(rem_sh);
                n_quot = {r_quot[ADDR_W-2:0], div_ge};
                n_cnt  = (r_cnt == '0) ? STEP_W'(NDISK_W - 1) : r_cnt - 1'b1;
            end
            FS_MOD: begin
                n_rem  = mod_ge ? r_rem - mod_sub : r_rem;
                n_disk = {r_disk[NDISK_W-2:0], mod_ge};
                n_cnt  = (r_cnt == '0) ? r_cnt : r_cnt - 1'b1;
            end
            FS_MUL: begin
                n_row_base = prod[ADDR_W-1:0];
            end
            default: begin
                n_cnt = r_cnt;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= FS_IDLE;
            r_failed <= 1'b0;
            r_dead   <= '0;
        end else begin
            r_state  <= n_state;
            r_failed <= n_failed;
            r_dead   <= n_dead;
        end
    end

    always_ff @(posedge i_clk) begin
        r_single   <= n_single;
        r_status   <= n_status;
        r_disk     <= n_disk;
        r_quot     <= n_quot;
        r_rem      <= n_rem;
        r_div      <= n_div;
        r_cnt      <= n_cnt;
        r_lba      <= n_lba;
        r_left     <= n_left;
        r_unit     <= n_unit;
        r_n        <= n_n;
        r_wr       <= n_wr;
        r_row_base <= n_row_base;
    end

    always_comb begin
        o_push_job.single   = r_single;
        o_push_job.status   = r_status;
        o_push_job.disk     = r_disk;
        o_push_job.row_base = r_row_base;
        o_push_job.offset   = r_rem[UNIT_W-1:0];
        o_push_job.lba      = r_lba;
        o_push_job.left     = r_left;
        o_push_job.unit     = r_unit;
        o_push_job.ndisks   = r_n;
        o_push_job.wr       = r_wr;
    end

endmodule

>>> sv/r0split_queue.sv
// ----------------------------------------------------------------------------
// r0split_queue
// short job queue between the address mapper and the chunk generator
// ----------------------------------------------------------------------------
module r0split_queue
    import r0split_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push_valid,
    output logic  o_push_ready,
    input  t_job  i_push_job,
    output logic  o_pop_valid,
    input  logic  i_pop_ready,
    output t_job  o_pop_job
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W_Q = $clog2(QUEUE_DEPTH + 1);

    t_job               r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CNT_W_Q-1:0] r_count, n_count;

    logic push, pop;

    assign o_push_ready = r_count != CNT_W_Q'(QUEUE_DEPTH);
    assign o_pop_valid  = r_count != '0;
    assign o_pop_job    = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (pop && !push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_job;
        end
    end

endmodule

>>> sv/r0split_back.sv
// ----------------------------------------------------------------------------
// r0split_back
// walks a mapped request strip by strip and registers each chunk result
// ----------------------------------------------------------------------------
module r0split_back
    import r0split_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_pop_valid,
    output logic                o_pop_ready,
    input  t_job                i_pop_job,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [1:0]          o_status,
    output logic [DISK_W-1:0]   o_disk_index,
    output logic [ADDR_W-1:0]   o_disk_block,
    output logic [CNT_W-1:0]    o_chunk_blocks,
    output logic                o_chunk_write,
    output logic                o_last
);

    logic               r_busy, n_busy;
    logic               r_single, n_single;
    t_status            r_status, n_status;
    logic [NDISK_W-1:0] r_disk, n_disk;
    logic [ADDR_W-1:0]  r_row_base, n_row_base;
    logic [UNIT_W-1:0]  r_offset, n_offset;
    logic [ADDR_W-1:0]  r_lba, n_lba;
    logic [CNT_W-1:0]   r_left, n_left;
    logic [UNIT_W-1:0]  r_unit, n_unit;
    logic [NDISK_W-1:0] r_n, n_n;
    logic               r_wr, n_wr;

    logic               r_out_valid, n_out_valid;
    t_status            r_out_status, n_out_status;
    logic [DISK_W-1:0]  r_out_disk, n_out_disk;
    logic [ADDR_W-1:0]  r_out_block, n_out_block;
    logic [CNT_W-1:0]   r_out_cnt, n_out_cnt;
    logic               r_out_wr, n_out_wr;
    logic               r_out_last, n_out_last;

    logic               out_free;
    logic               emit;
    logic               pop;
    logic [UNIT_W:0]    room;
    logic [CNT_W-1:0]   cnt;
    logic [CNT_W-1:0]   left_after;
    logic [ADDR_W:0]    lba_sum;
    logic [NDISK_W-1:0] disk_inc;

    assign out_free    = !r_out_valid || i_out_ready;
    assign emit        = r_busy && out_free;
    assign o_pop_ready = !r_busy;
    assign pop         = i_pop_valid && o_pop_ready;

    // chunk stops at the strip end or the request end
    assign room       = {1'b0, r_unit} - {1'b0, r_offset};
    assign cnt        = ((UNIT_W + 1)'(r_left) < room) ? r_left : room[CNT_W-1:0];
    assign left_after = r_left - cnt;
    assign lba_sum    = {1'b0, r_lba} + (ADDR_W + 1)'(cnt);
    assign disk_inc   = r_disk + NDISK_W'(1);

    always_comb begin
        n_busy     = r_busy;
        n_single   = r_single;
        n_status   = r_status;
        n_disk     = r_disk;
        n_row_base = r_row_base;
        n_offset   = r_offset;
        n_lba      = r_lba;
        n_left     = r_left;
        n_unit     = r_unit;
        n_n        = r_n;
        n_wr       = r_wr;

        n_out_valid  = r_out_valid && !i_out_ready;
        n_out_status = r_out_status;
        n_out_disk   = r_out_disk;
        n_out_block  = r_out_block;
        n_out_cnt    = r_out_cnt;
        n_out_wr     = r_out_wr;
        n_out_last   = r_out_last;

        if (pop) begin
            n_busy     = 1'b1;
            n_single   = i_pop_job.single;
            n_status   = i_pop_job.status;
            n_disk     = i_pop_job.disk;
            n_row_base = i_pop_job.row_base;
            n_offset   = i_pop_job.offset;
            n_lba      = i_pop_job.lba;
            n_left     = i_pop_job.left;
            n_unit     = i_pop_job.unit;
            n_n        = i_pop_job.ndisks;
            n_wr       = i_pop_job.wr;
        end else if (emit) begin
            n_out_valid = 1'b1;
            n_out_disk  = r_disk[DISK_W-1:0];
            n_out_wr    = r_wr;
            if (r_single) begin
                n_out_status = r_status;
                n_out_block  = '0;
                n_out_cnt    = '0;
                n_out_last   = 1'b1;
                n_busy       = 1'b0;
            end else begin
                n_out_status = ST_CHUNK;
                n_out_block  = r_row_base + ADDR_W'(r_offset);
                n_out_cnt    = cnt;
                n_out_last   = left_after == '0;
                n_busy       = left_after != '0;
                n_left       = left_after;
                n_lba        = lba_sum[ADDR_W-1:0];
                if (lba_sum[ADDR_W]) begin
                    // ran past the top address: wrap to disk zero, row zero
                    n_disk     = '0;
                    n_row_base = '0;
                    n_offset   = lba_sum[UNIT_W-1:0];
                end else begin
                    n_offset = '0;
                    if (disk_inc == r_n) begin
                        n_disk     = '0;
                        n_row_base = r_row_base + ADDR_W'(r_unit);
                    end else begin
                        n_disk = disk_inc;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_single     <= n_single;
        r_status     <= n_status;
        r_disk       <= n_disk;
        r_row_base   <= n_row_base;
        r_offset     <= n_offset;
        r_lba        <= n_lba;
        r_left       <= n_left;
        r_unit       <= n_unit;
        r_n          <= n_n;
        r_wr         <= n_wr;
        r_out_status <= n_out_status;
        r_out_disk   <= n_out_disk;
        r_out_block  <= n_out_block;
        r_out_cnt    <= n_out_cnt;
        r_out_wr     <= n_out_wr;
        r_out_last   <= n_out_last;
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_out_status;
    assign o_disk_index   = r_out_disk;
    assign o_disk_block   = r_out_block;
    assign o_chunk_blocks = r_out_cnt;
    assign o_chunk_write  = r_out_wr;
    assign o_last         = r_out_last;

endmodule

>>> sv/raid0_stripe_request_splitter.sv
// ----------------------------------------------------------------------------
// raid0_stripe_request_splitter
// splits volume requests into per-disk chunk commands for a striped set
// ----------------------------------------------------------------------------
// path: a request's first chunk follows its transfer through the bit-serial
//   address divide, disk select, multiply, queue and output register
// flow: the front takes no new request until it has pushed the last one to the
//   queue; the back end emits one chunk per cycle behind it while the sink is ready
// error, failure and empty requests: one result each, with no address divide
// reset: synchronous active low; clears volume failure, queue and output valid,
//   loads stripe unit 4 and disk count 2
module raid0_stripe_request_splitter
    import r0split_pkg::*;
#(
    parameter int MAX_DISKS   = DEF_MAX_DISKS,
    parameter int MAX_UNIT    = DEF_MAX_UNIT,
    parameter int MAX_REQUEST = DEF_MAX_REQUEST
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration write port
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    // request channel
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic                 i_action,
    input  logic                 i_is_write,
    input  logic [ADDR_W-1:0]    i_first_block,
    input  logic [CNT_W-1:0]     i_block_count,
    input  logic [DISK_W-1:0]    i_failing_disk,
    // result channel
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [1:0]           o_status,
    output logic [DISK_W-1:0]    o_disk_index,
    output logic [ADDR_W-1:0]    o_disk_block,
    output logic [CNT_W-1:0]     o_chunk_blocks,
    output logic                 o_chunk_write,
    output logic                 o_last
);

    // configuration registers; written only while the block is idle is a user rule, not enforced here
    logic [UNIT_W-1:0]  r_stripe_unit, n_stripe_unit;
    logic [NDISK_W-1:0] r_disk_count, n_disk_count;

    always_comb begin
        n_stripe_unit = r_stripe_unit;
        n_disk_count  = r_disk_count;
        if (i_cfg_we) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_STRIPE_UNIT: n_stripe_unit = i_cfg_data[UNIT_W-1:0];
                CFG_DISK_COUNT:  n_disk_count  = i_cfg_data[NDISK_W-1:0];
                default: begin
                    n_stripe_unit = r_stripe_unit;
                    n_disk_count  = r_disk_count;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stripe_unit <= RST_STRIPE_UNIT;
            r_disk_count  <= RST_DISK_COUNT;
        end else begin
            r_stripe_unit <= n_stripe_unit;
            r_disk_count  <= n_disk_count;
        end
    end

    // front to queue
    logic push_valid, push_ready;
    t_job push_job;
    // queue to back
    logic pop_valid, pop_ready;
    t_job pop_job;

    // front: failure tracking, classification and start address mapping
    r0split_front #(
        .MAX_DISKS   (MAX_DISKS),
        .MAX_UNIT    (MAX_UNIT),
        .MAX_REQUEST (MAX_REQUEST)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_stripe_unit  (r_stripe_unit),
        .i_disk_count   (r_disk_count),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_action       (i_action),
        .i_is_write     (i_is_write),
        .i_first_block  (i_first_block),
        .i_block_count  (i_block_count),
        .i_failing_disk (i_failing_disk),
        .o_push_valid   (push_valid),
        .i_push_ready   (push_ready),
        .o_push_job     (push_job)
    );

    // mapped jobs wait here so the front can start the next divide
    r0split_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_job   (push_job),
        .o_pop_valid  (pop_valid),
        .i_pop_ready  (pop_ready),
        .o_pop_job    (pop_job)
    );

    // back: one chunk per transfer, output register decouples the sink
    r0split_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_pop_valid    (pop_valid),
        .o_pop_ready    (pop_ready),
        .i_pop_job      (pop_job),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_status       (o_status),
        .o_disk_index   (o_disk_index),
        .o_disk_block   (o_disk_block),
        .o_chunk_blocks (o_chunk_blocks),
        .o_chunk_write  (o_chunk_write),
        .o_last         (o_last)
    );

endmodule

>>> sv/r0split_checker.sv
// ----------------------------------------------------------------------------
// r0split_checker
// port-level checks on the result channel, bound to the top level
// ----------------------------------------------------------------------------
module r0split_checker
    import r0split_pkg::*;
#(
    parameter int MAX_REQUEST = DEF_MAX_REQUEST
) (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_out_valid,
    input logic                 i_out_ready,
    input logic [1:0]           o_status,
    input logic [ADDR_W-1:0]    o_disk_block,
    input logic [CNT_W-1:0]     o_chunk_blocks,
    input logic                 o_last
);

    // result valid holds until transfer
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped before transfer");

    // no result is offered right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // a chunk carries blocks and stays within the request limit
    a_chunk_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == ST_CHUNK |->
            o_chunk_blocks != '0 && 32'(o_chunk_blocks) <= 32'(MAX_REQUEST))
        else $error("chunk size out of range");

    // error and acknowledge results are single, final and carry no blocks
    a_single_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != ST_CHUNK |->
            o_last && o_disk_block == '0 && o_chunk_blocks == '0)
        else $error("malformed non-chunk result");

endmodule

bind raid0_stripe_request_splitter r0split_checker #(
    .MAX_REQUEST (MAX_REQUEST)
) u_r0split_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_status       (o_status),
    .o_disk_block   (o_disk_block),
    .o_chunk_blocks (o_chunk_blocks),
    .o_last         (o_last)
);
